@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the AT response line sequencer.
// Depends on nothing; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/atrls_pkg.sv @@
// Types and constants of the AT response line sequencer.
// Used by the line classifier and the top level; depends on nothing.
package atrls_pkg;

    localparam int HEAD_LEN = 11;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_I   = 8'h49;
    localparam logic [7:0] CH_UP_J   = 8'h4A;
    localparam logic [7:0] CH_UP_K   = 8'h4B;
    localparam logic [7:0] CH_UP_O   = 8'h4F;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_UP_V   = 8'h56;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_E   = 8'h65;

    typedef logic [HEAD_LEN-1:0][7:0] t_line_head;

    typedef enum logic [2:0] {
        KIND_OK      = 3'd0,
        KIND_ERROR   = 3'd1,
        KIND_MENU    = 3'd2,
        KIND_REJECT  = 3'd3,
        KIND_ABORT   = 3'd4,
        KIND_KEY     = 3'd5,
        KIND_UNKNOWN = 3'd6
    } t_line_kind;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_ECHO_ON    = 3'd1,
        CMD_CHARSET    = 3'd2,
        CMD_MENU_ITEM  = 3'd3,
        CMD_EVENTS_ON  = 3'd4,
        CMD_DIALOG     = 3'd5,
        CMD_EMPTY      = 3'd6,
        CMD_EVENTS_OFF = 3'd7
    } t_send_cmd;

    typedef enum logic [3:0] {
        STEP_NONE        = 4'd0,
        STEP_SYNC        = 4'd1,
        STEP_ECHO        = 4'd2,
        STEP_CHARSET     = 4'd3,
        STEP_ACCESSORY   = 4'd4,
        STEP_EVENTS_ON   = 4'd5,
        STEP_EVENTS_OFF  = 4'd6,
        STEP_DIALOG      = 4'd7,
        STEP_ASIDE       = 4'd8
    } t_step;

    typedef struct packed {
        logic        emit;
        t_line_kind  kind;
        t_send_cmd   cmd;
        logic [14:0] key;
        logic        rel;
        t_step       next_step;
        logic        next_cancel;
    } t_cls_result;

endpackage

@@ hdl/atrls_line_classify.sv @@
// Classifies one completed line from its first characters and clipped length.
// Depends on atrls_pkg for the character codes, enums and result struct.
module atrls_line_classify (
    input  atrls_pkg::t_line_head  i_head,
    input  logic [3:0]             i_len,
    input  atrls_pkg::t_step       i_step,
    input  logic                   i_cancel,
    output atrls_pkg::t_cls_result o_res
);
    import atrls_pkg::*;

    logic       w_is_ok;
    logic       w_is_error;
    logic       w_is_eaai;
    logic       w_pre_eaii;
    logic       w_is_eaii;
    logic       w_is_eaii0;
    logic       w_pre_ckev;
    logic       w_pre_echo;
    logic       w_two;
    logic [7:0] w_first;
    logic [7:0] w_last;
    logic [7:0] w_rel_char;
    logic [14:0] w_code;

    assign w_pre_echo = (i_len >= 4'd3) && i_head[0] == CH_UP_E && i_head[1] == CH_COLON
                        && i_head[2] == CH_SPACE;
    assign w_is_ok    = (i_len == 4'd2) && i_head[0] == CH_UP_O && i_head[1] == CH_UP_K;
    assign w_is_error = (i_len == 4'd5) && i_head[0] == CH_UP_E && i_head[1] == CH_UP_R
                        && i_head[2] == CH_UP_R && i_head[3] == CH_UP_O
                        && i_head[4] == CH_UP_R;
    assign w_is_eaai  = (i_len == 4'd5) && i_head[0] == CH_STAR && i_head[1] == CH_UP_E
                        && i_head[2] == CH_UP_A && i_head[3] == CH_UP_A
                        && i_head[4] == CH_UP_I;
    assign w_pre_eaii = i_head[0] == CH_STAR && i_head[1] == CH_UP_E && i_head[2] == CH_UP_A
                        && i_head[3] == CH_UP_I && i_head[4] == CH_UP_I;
    assign w_is_eaii  = (i_len == 4'd5) && w_pre_eaii;
    assign w_is_eaii0 = (i_len == 4'd8) && w_pre_eaii && i_head[5] == CH_COLON
                        && i_head[6] == CH_SPACE && i_head[7] == CH_ZERO;
    assign w_pre_ckev = (i_len >= 4'd6) && i_head[0] == CH_PLUS && i_head[1] == CH_UP_C
                        && i_head[2] == CH_UP_K && i_head[3] == CH_UP_E
                        && i_head[4] == CH_UP_V && i_head[5] == CH_COLON;

    assign w_first    = i_head[7];
    assign w_two      = i_head[8] != CH_COMMA;
    assign w_last     = w_two ? i_head[8] : i_head[7];
    assign w_rel_char = w_two ? i_head[10] : i_head[9];
    assign w_code     = w_two ? {i_head[7][6:0], i_head[8]} : {7'd0, i_head[7]};

    always_comb begin
        o_res             = '0;
        o_res.emit        = 1'b1;
        o_res.kind        = KIND_UNKNOWN;
        o_res.cmd         = CMD_NONE;
        o_res.next_step   = i_step;
        o_res.next_cancel = i_cancel;
        priority if (i_step == STEP_SYNC) begin
            o_res.emit = 1'b0;
            if (w_pre_echo) begin
                o_res.next_step = STEP_ECHO;
            end
        end else if (w_is_error) begin
            o_res.kind      = KIND_ERROR;
            o_res.next_step = STEP_NONE;
        end else if (w_is_ok) begin
            o_res.kind = KIND_OK;
            unique case (i_step)
                STEP_ECHO: begin
                    o_res.cmd       = CMD_ECHO_ON;
                    o_res.next_step = STEP_CHARSET;
                end
                STEP_CHARSET: begin
                    o_res.cmd       = CMD_CHARSET;
                    o_res.next_step = STEP_ACCESSORY;
                end
                STEP_ACCESSORY: begin
                    o_res.cmd       = CMD_MENU_ITEM;
                    o_res.next_step = STEP_NONE;
                end
                STEP_EVENTS_ON: begin
                    o_res.cmd       = CMD_EVENTS_ON;
                    o_res.next_step = STEP_NONE;
                end
                STEP_DIALOG: begin
                    o_res.cmd       = CMD_DIALOG;
                    o_res.next_step = STEP_EVENTS_ON;
                end
                STEP_ASIDE: begin
                    o_res.rel       = 1'b1;
                    o_res.next_step = STEP_SYNC;
                end
                default: begin
                    o_res.cmd = CMD_NONE;
                end
            endcase
        end else if (w_is_eaai) begin
            o_res.kind      = KIND_MENU;
            o_res.cmd       = CMD_EMPTY;
            o_res.next_step = STEP_DIALOG;
        end else if (w_is_eaii0) begin
            o_res.kind      = KIND_REJECT;
            o_res.cmd       = CMD_EVENTS_OFF;
            o_res.next_step = STEP_DIALOG;
        end else if (w_is_eaii) begin
            o_res.kind      = KIND_ABORT;
            o_res.cmd       = CMD_EVENTS_OFF;
            o_res.next_step = STEP_ASIDE;
        end else if (w_pre_ckev) begin
            o_res.kind = KIND_KEY;
            o_res.key  = w_code;
            priority if (w_rel_char == CH_ZERO) begin
                o_res.key = '0;
            end else if (w_last == CH_LO_E) begin
                if (i_cancel) begin
                    o_res.key         = '0;
                    o_res.next_cancel = 1'b0;
                end
            end else if (w_last == CH_RBRACK) begin
                o_res.next_cancel = 1'b1;
            end else if ((w_last == CH_UP_J || w_last == CH_UP_R) && w_two
                         && w_first == CH_COLON) begin
                o_res.next_cancel = 1'b1;
            end else begin
                o_res.next_cancel = i_cancel;
            end
        end else begin
            o_res.kind = KIND_UNKNOWN;
        end
    end

endmodule

@@ hdl/at_response_line_sequencer_core.sv @@
// Top level of the AT response line sequencer: input register, line head
// store, step state and output register. Depends on atrls_pkg,
// atrls_line_classify and assert_macros.svh.
//
//  channel | dir | beat contents
//  s       | in  | tdata[7:0] rx_byte
//  m       | out | tdata[2:0] line_kind, [5:3] send_cmd, [20:6] key_code,
//          |     |      [21] release_link, [23:22] zero
//
// One byte a cycle unless a waiting result stalls the input: the beat that
// completes a line goes from the input register through the line classifier
// into the output register, where its result stays valid until it is taken.
// Synchronous active-low reset empties both registers, clears the line length
// and the cancel filter, and sets the step to sync waiting.
// The input stays ready while a result waits, until the input register fills.
`include "assert_macros.svh"

module at_response_line_sequencer_core #(
    parameter int LINE_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // line_kind, send_cmd, key_code, release_link
);
    import atrls_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_MAX - 2);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [LEN_W-1:0] r_len;
    t_line_head       r_head;
    t_step            r_step;
    logic             r_cancel;
    logic             r_out_valid;
    t_cls_result      r_out;

    logic        w_adv;
    logic        w_fin;
    logic        w_char;
    t_line_head  w_head;
    logic [3:0]  w_len4;
    t_cls_result w_cls;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_fin      = w_adv && r_in_byte == CH_LF && r_len != '0;
    assign w_char     = w_adv && r_in_byte != CH_LF && r_in_byte != CH_CR;
    assign w_len4     = (r_len > LEN_W'(15)) ? 4'd15 : r_len[3:0];

    always_comb begin
        for (int i = 0; i < HEAD_LEN; i++) begin
            w_head[i] = (LEN_W'(i) < r_len) ? r_head[i] : 8'd0;
        end
    end

    atrls_line_classify u_classify (
        .i_head   (w_head),
        .i_len    (w_len4),
        .i_step   (r_step),
        .i_cancel (r_cancel),
        .o_res    (w_cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_len       <= '0;
            r_step      <= STEP_SYNC;
            r_cancel    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
                r_in_byte  <= i_s_tdata;
            end
            if (w_fin && w_cls.emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_cls;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fin) begin
                r_step   <= w_cls.next_step;
                r_cancel <= w_cls.next_cancel;
            end
            if (w_adv && r_in_byte == CH_LF) begin
                r_len <= '0;
            end else if (w_char && r_len < CAP) begin
                r_len <= r_len + 1'b1;
                for (int i = 0; i < HEAD_LEN; i++) begin
                    if (r_len == LEN_W'(i)) begin
                        r_head[i] <= r_in_byte;
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.rel, r_out.key, r_out.cmd, r_out.kind};

    `ASSERT_CLK(a_len_in_range, i_clk, i_rst_n, r_len <= CAP)
    `ASSERT_CLK(a_emit_on_lf, i_clk, i_rst_n, (w_adv && w_cls.emit && w_fin) |-> r_in_byte == CH_LF)
    `ASSERT_CLK(a_lf_clears_len, i_clk, i_rst_n, (w_adv && r_in_byte == CH_LF) |=> r_len == '0)
    `ASSERT_CLK(a_sync_silent, i_clk, i_rst_n, (w_fin && r_step == STEP_SYNC) |=> !$rose(r_out_valid))
    `ASSERT_CLK(a_release_on_ok, i_clk, i_rst_n, (r_out_valid && r_out.rel) |-> r_out.kind == KIND_OK)

endmodule
